// File: hw/rtl/gfau_pkg.sv
package gfau_pkg;

   localparam int ElemWidth = 8;
   localparam int ExpWidth  = 16;
   localparam int OpWidth   = 2;
   localparam int FieldOrder = 256;
   // nonzero elements form a cyclic group of this order
   localparam int GroupOrder = FieldOrder - 1;
   // x^8 folded back by 0x11d
   localparam logic [ElemWidth-1:0] PolyLow = 8'h1d;

   typedef enum logic [OpWidth-1:0] {
      OP_ADD = 2'd0,
      OP_MUL = 2'd1,
      OP_DIV = 2'd2,
      OP_POW = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RES_XOR  = 2'd0,
      RES_ZERO = 2'd1,
      RES_ONE  = 2'd2,
      RES_EXP  = 2'd3
   } res_kind_type;

   // one table write per cycle during the fill sweep
   typedef struct packed {
      logic                 busy;
      logic                 we;
      logic [ElemWidth-1:0] idx;
      logic [ElemWidth-1:0] elem;
   } fill_wr_type;

   function automatic logic [ElemWidth-1:0] xtime(input logic [ElemWidth-1:0] x);
      logic [ElemWidth-1:0] sh;
      sh = {x[ElemWidth-2:0], 1'b0};
      return x[ElemWidth-1] ? (sh ^ PolyLow) : sh;
   endfunction

endpackage

// File: hw/rtl/gfau_ram.sv
module gfau_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/gfau_fill.sv
module gfau_fill (
   input  logic                clock,
   input  logic                reset,
   output gfau_pkg::fill_wr_type fill
);

   logic                          active_ff, active_in;
   logic [gfau_pkg::ElemWidth-1:0] count_ff, count_in;
   logic [gfau_pkg::ElemWidth-1:0] elem_ff, elem_in;

   localparam logic [gfau_pkg::ElemWidth-1:0] LastIdx =
      gfau_pkg::ElemWidth'(gfau_pkg::GroupOrder - 1);

   // walk the powers of the generator x: exp[i] = elem, log[elem] = i
   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      elem_in   = elem_ff;
      if (active_ff) begin
         if (count_ff == LastIdx) begin
            active_in = 1'b0;
         end
         count_in = count_ff + 1'b1;
         elem_in  = gfau_pkg::xtime(elem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         count_ff  <= '0;
         elem_ff   <= gfau_pkg::ElemWidth'(1);
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
         elem_ff   <= elem_in;
      end
   end

   assign fill.busy = active_ff;
   assign fill.we   = active_ff;
   assign fill.idx  = count_ff;
   assign fill.elem = elem_ff;

endmodule

// File: hw/rtl/gf256_arithmetic_unit.sv
// channel   ports                                             direction  handshake
// request   req_opcode, req_operand_a, req_operand_b          in         start & !busy
// response  rsp_field_result, rsp_divide_by_zero              out        rsp_valid, one cycle
//
// one word accepted per cycle once the tables are built; after its request is accepted a
// result passes the log read at that edge, the exp read and the output register
// after reset busy stays high while the log and exp tables are swept in,
// one element per cycle
// the response side cannot stall, so busy never rises again after the sweep
module gf256_arithmetic_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_operand_a,
   input  logic [15:0] req_operand_b,
   output logic        rsp_valid,
   output logic [7:0]  rsp_field_result,
   output logic        rsp_divide_by_zero
);

   localparam int EW = gfau_pkg::ElemWidth;
   localparam logic [EW:0] Group9 = (EW + 1)'(gfau_pkg::GroupOrder);

   gfau_pkg::fill_wr_type fill;
   logic                  accept;
   logic [EW-1:0]         log_a, log_b, exp_rd;
   logic [EW-1:0]         exp_addr;

   gfau_fill u_fill (
      .clock(clock),
      .reset(reset),
      .fill (fill)
   );

   assign busy   = fill.busy;
   assign accept = start & ~fill.busy;

   // two copies of the log table so both operands look up in the same cycle
   gfau_ram #(.WIDTH(EW), .DEPTH(gfau_pkg::FieldOrder)) u_log_a (
      .clock  (clock),
      .wr_en  (fill.we),
      .wr_addr(fill.elem),
      .wr_data(fill.idx),
      .rd_addr(req_operand_a),
      .rd_data(log_a)
   );

   gfau_ram #(.WIDTH(EW), .DEPTH(gfau_pkg::FieldOrder)) u_log_b (
      .clock  (clock),
      .wr_en  (fill.we),
      .wr_addr(fill.elem),
      .wr_data(fill.idx),
      .rd_addr(req_operand_b[EW-1:0]),
      .rd_data(log_b)
   );

   gfau_ram #(.WIDTH(EW), .DEPTH(gfau_pkg::FieldOrder)) u_exp (
      .clock  (clock),
      .wr_en  (fill.we),
      .wr_addr(fill.idx),
      .wr_data(fill.elem),
      .rd_addr(exp_addr),
      .rd_data(exp_rd)
   );

   // stage 1: exponent reduced mod 255 while the log tables are read
   logic            s1_valid_ff;
   gfau_pkg::op_type s1_op_ff;
   logic [EW-1:0]   s1_a_ff, s1_b_ff, s1_emod_ff;
   logic            s1_ezero_ff;
   logic [EW:0]     efold, efold_sub;
   logic [EW-1:0]   emod_in;

   always_comb begin
      efold     = {1'b0, req_operand_b[15:8]} + {1'b0, req_operand_b[7:0]};
      efold_sub = (efold >= Group9) ? (efold - Group9) : efold;
      emod_in   = (efold_sub == Group9) ? '0 : efold_sub[EW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_op_ff    <= gfau_pkg::op_type'(req_opcode);
      s1_a_ff     <= req_operand_a;
      s1_b_ff     <= req_operand_b[EW-1:0];
      s1_emod_ff  <= emod_in;
      s1_ezero_ff <= (req_operand_b == '0);
   end

   // stage 2: log-domain index and special-case class
   logic                      s2_valid_ff;
   gfau_pkg::res_kind_type    s2_kind_ff, kind_in;
   logic [EW-1:0]             s2_xor_ff;
   logic                      s2_dz_ff, dz_in;
   logic [EW:0]               lsum, ldiff, idx9;
   logic [2*EW-1:0]           lprod;
   logic [EW:0]               pfold;

   always_comb begin
      lsum   = {1'b0, log_a} + {1'b0, log_b};
      ldiff  = {1'b0, log_a} - {1'b0, log_b};
      lprod  = log_a * s1_emod_ff;
      pfold  = {1'b0, lprod[2*EW-1:EW]} + {1'b0, lprod[EW-1:0]};
      kind_in = gfau_pkg::RES_EXP;
      dz_in   = 1'b0;
      idx9    = '0;
      case (s1_op_ff)
         gfau_pkg::OP_ADD: begin
            kind_in = gfau_pkg::RES_XOR;
         end
         gfau_pkg::OP_MUL: begin
            idx9 = (lsum >= Group9) ? (lsum - Group9) : lsum;
            if (s1_a_ff == '0 || s1_b_ff == '0) begin
               kind_in = gfau_pkg::RES_ZERO;
            end
         end
         gfau_pkg::OP_DIV: begin
            // borrow out means log_a < log_b
            idx9 = ldiff[EW] ? (ldiff + Group9) : ldiff;
            if (s1_b_ff == '0) begin
               kind_in = gfau_pkg::RES_ZERO;
               dz_in   = 1'b1;
            end else if (s1_a_ff == '0) begin
               kind_in = gfau_pkg::RES_ZERO;
            end
         end
         gfau_pkg::OP_POW: begin
            idx9 = (pfold >= Group9) ? (pfold - Group9) : pfold;
            if (s1_ezero_ff) begin
               kind_in = gfau_pkg::RES_ONE;
            end else if (s1_a_ff == '0) begin
               kind_in = gfau_pkg::RES_ZERO;
            end
         end
         default: begin
            kind_in = gfau_pkg::RES_ZERO;
         end
      endcase
      exp_addr = idx9[EW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_kind_ff <= kind_in;
      s2_xor_ff  <= s1_a_ff ^ s1_b_ff;
      s2_dz_ff   <= dz_in;
   end

   // stage 3: pick the word and register it for the response
   logic          rsp_valid_ff;
   logic [EW-1:0] rsp_field_result_ff, res_in;
   logic          rsp_divide_by_zero_ff;

   always_comb begin
      case (s2_kind_ff)
         gfau_pkg::RES_XOR:  res_in = s2_xor_ff;
         gfau_pkg::RES_ZERO: res_in = '0;
         gfau_pkg::RES_ONE:  res_in = EW'(1);
         gfau_pkg::RES_EXP:  res_in = exp_rd;
         default:            res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
      rsp_field_result_ff   <= res_in;
      rsp_divide_by_zero_ff <= s2_dz_ff;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_field_result   = rsp_field_result_ff;
   assign rsp_divide_by_zero = rsp_divide_by_zero_ff;

endmodule

// File: tb/tb_gf256_arithmetic_unit.sv
module tb_gf256_arithmetic_unit;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [gfau_pkg::ElemWidth-1:0] elem;
      logic                           dz;
   } gf_outcome_type;

   typedef struct {
      gfau_pkg::op_type               op;
      logic [gfau_pkg::ElemWidth-1:0] a;
      logic [gfau_pkg::ExpWidth-1:0]  b;
      bit                             typed;
      logic [gfau_pkg::ElemWidth-1:0] elem;
      logic                           dz;
   } gf_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [1:0]                     req_opcode = '0;
   logic [gfau_pkg::ElemWidth-1:0] req_operand_a = '0;
   logic [gfau_pkg::ExpWidth-1:0]  req_operand_b = '0;
   logic                           rsp_valid;
   logic [gfau_pkg::ElemWidth-1:0] rsp_field_result;
   logic                           rsp_divide_by_zero;

   gf_outcome_type owed_outcomes[$];
   gf_outcome_type oldest_outcome;
   int             mismatches = 0;
   int             results_checked = 0;
   int             zero_divisors_seen = 0;
   int             words_per_op[4] = '{0, 0, 0, 0};
   bit             drain_timeout = 1'b0;

   // rows with a typed value are checked against it, the rest against the field arithmetic
   gf_row_type gf_plan[25] = '{
      '{gfau_pkg::OP_ADD, 8'h00, 16'h0000, 1'b1, 8'h00, 1'b0},
      '{gfau_pkg::OP_ADD, 8'hff, 16'h00ff, 1'b1, 8'h00, 1'b0},
      '{gfau_pkg::OP_ADD, 8'ha5, 16'hff5a, 1'b1, 8'hff, 1'b0},
      '{gfau_pkg::OP_ADD, 8'h3c, 16'h8000, 1'b1, 8'h3c, 1'b0},
      '{gfau_pkg::OP_MUL, 8'h00, 16'h00ff, 1'b1, 8'h00, 1'b0},
      '{gfau_pkg::OP_MUL, 8'h01, 16'h00ff, 1'b1, 8'hff, 1'b0},
      '{gfau_pkg::OP_MUL, 8'h80, 16'h0002, 1'b1, 8'h1d, 1'b0},
      '{gfau_pkg::OP_MUL, 8'h02, 16'hff80, 1'b1, 8'h1d, 1'b0},
      '{gfau_pkg::OP_MUL, 8'hff, 16'h00ff, 1'b0, 8'h00, 1'b0},
      '{gfau_pkg::OP_MUL, 8'hc3, 16'ha55a, 1'b0, 8'h00, 1'b0},
      '{gfau_pkg::OP_DIV, 8'h00, 16'h0007, 1'b1, 8'h00, 1'b0},
      '{gfau_pkg::OP_DIV, 8'h37, 16'h0000, 1'b1, 8'h00, 1'b1},
      '{gfau_pkg::OP_DIV, 8'h37, 16'hff00, 1'b1, 8'h00, 1'b1},
      '{gfau_pkg::OP_DIV, 8'hff, 16'h00ff, 1'b1, 8'h01, 1'b0},
      '{gfau_pkg::OP_DIV, 8'h1d, 16'h0080, 1'b1, 8'h02, 1'b0},
      '{gfau_pkg::OP_DIV, 8'h01, 16'h7f02, 1'b0, 8'h00, 1'b0},
      '{gfau_pkg::OP_POW, 8'h00, 16'h0000, 1'b1, 8'h01, 1'b0},
      '{gfau_pkg::OP_POW, 8'h57, 16'h0000, 1'b1, 8'h01, 1'b0},
      '{gfau_pkg::OP_POW, 8'h00, 16'h0001, 1'b1, 8'h00, 1'b0},
      '{gfau_pkg::OP_POW, 8'h00, 16'hffff, 1'b1, 8'h00, 1'b0},
      '{gfau_pkg::OP_POW, 8'hff, 16'h0001, 1'b1, 8'hff, 1'b0},
      '{gfau_pkg::OP_POW, 8'h02, 16'h0008, 1'b1, 8'h1d, 1'b0},
      '{gfau_pkg::OP_POW, 8'h02, 16'h00ff, 1'b1, 8'h01, 1'b0},
      '{gfau_pkg::OP_POW, 8'hff, 16'hffff, 1'b0, 8'h00, 1'b0},
      '{gfau_pkg::OP_POW, 8'h03, 16'h8000, 1'b0, 8'h00, 1'b0}
   };

   gf256_arithmetic_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .rsp_valid          (rsp_valid),
      .rsp_field_result   (rsp_field_result),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shift-and-add product, folding x^8 back as the low byte of the polynomial
   function automatic logic [gfau_pkg::ElemWidth-1:0] gf_product(
      input logic [gfau_pkg::ElemWidth-1:0] x,
      input logic [gfau_pkg::ElemWidth-1:0] y);
      logic [gfau_pkg::ElemWidth-1:0] acc;
      logic [gfau_pkg::ElemWidth-1:0] m;
      logic [gfau_pkg::ElemWidth-1:0] sh;
      acc = '0;
      m = x;
      for (int i = 0; i < gfau_pkg::ElemWidth; i++) begin
         if (y[i]) acc = acc ^ m;
         sh = {m[gfau_pkg::ElemWidth-2:0], 1'b0};
         m = m[gfau_pkg::ElemWidth-1] ? (sh ^ gfau_pkg::PolyLow) : sh;
      end
      return acc;
   endfunction

   function automatic logic [gfau_pkg::ElemWidth-1:0] gf_power(
      input logic [gfau_pkg::ElemWidth-1:0] base,
      input logic [gfau_pkg::ExpWidth-1:0]  e);
      logic [gfau_pkg::ElemWidth-1:0] acc;
      logic [gfau_pkg::ElemWidth-1:0] sq;
      acc = 8'h01;
      sq = base;
      for (int i = 0; i < gfau_pkg::ExpWidth; i++) begin
         if (e[i]) acc = gf_product(acc, sq);
         sq = gf_product(sq, sq);
      end
      return acc;
   endfunction

   function automatic gf_outcome_type gf_evaluate(
      input gfau_pkg::op_type               op,
      input logic [gfau_pkg::ElemWidth-1:0] a,
      input logic [gfau_pkg::ExpWidth-1:0]  b);
      gf_outcome_type r;
      r.elem = '0;
      r.dz = 1'b0;
      case (op)
         gfau_pkg::OP_ADD: r.elem = a ^ b[gfau_pkg::ElemWidth-1:0];
         gfau_pkg::OP_MUL: r.elem = gf_product(a, b[gfau_pkg::ElemWidth-1:0]);
         gfau_pkg::OP_DIV: begin
            if (b[gfau_pkg::ElemWidth-1:0] == '0) begin
               r.dz = 1'b1;
            end else begin
               // inverse is b^(q-2) in the multiplicative group
               r.elem = gf_product(a, gf_power(b[gfau_pkg::ElemWidth-1:0],
                                               gfau_pkg::ExpWidth'(gfau_pkg::GroupOrder - 1)));
            end
         end
         default: r.elem = gf_power(a, b);
      endcase
      return r;
   endfunction

   function automatic logic [gfau_pkg::ElemWidth-1:0] pick_element();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         2: return 8'h01;
         default: return r[gfau_pkg::ElemWidth-1:0];
      endcase
   endfunction

   function automatic logic [gfau_pkg::ExpWidth-1:0] pick_operand_b(
      input gfau_pkg::op_type op);
      logic [31:0] r;
      logic [31:0] k;
      r = $urandom;
      k = $urandom_range(0, 257);
      if (op == gfau_pkg::OP_POW) begin
         case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return gfau_pkg::ExpWidth'(k * gfau_pkg::GroupOrder);
            3: return gfau_pkg::ExpWidth'(r[3:0]) + 16'd1;
            default: return r[gfau_pkg::ExpWidth-1:0];
         endcase
      end
      case ($urandom_range(0, 5))
         0: return {r[15:8], 8'h00};
         1: return {r[15:8], 8'hff};
         default: return r[gfau_pkg::ExpWidth-1:0];
      endcase
   endfunction

   task automatic send_word(input gfau_pkg::op_type op,
                            input logic [gfau_pkg::ElemWidth-1:0] a,
                            input logic [gfau_pkg::ExpWidth-1:0] b, input bit typed,
                            input gf_outcome_type typed_outcome);
      gf_outcome_type want;
      want = typed ? typed_outcome : gf_evaluate(op, a, b);
      req_opcode <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      owed_outcomes.push_back(want);
      words_per_op[op]++;
   endtask

   task automatic pause_sender(input int cycles);
      logic [31:0] noise;
      noise = $urandom;
      start <= 1'b0;
      // garbage on the request lines while start is low
      req_opcode <= noise[1:0];
      req_operand_a <= noise[9:2];
      req_operand_b <= noise[25:10];
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      int               sent;
      int               burst;
      int               gap;
      int               waited;
      logic [31:0]      r;
      gfau_pkg::op_type op;
      gf_outcome_type   none;
      none = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // first word is presented while the tables are still being swept and held until busy falls
      foreach (gf_plan[i]) begin
         send_word(gf_plan[i].op, gf_plan[i].a, gf_plan[i].b, gf_plan[i].typed,
                   '{gf_plan[i].elem, gf_plan[i].dz});
      end

      sent = 0;
      while (sent < 700) begin
         burst = $urandom_range(1, 60);
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
         if (gap != 0) pause_sender(gap);
         for (int k = 0; k < burst; k++) begin
            r = $urandom;
            op = gfau_pkg::op_type'(r[1:0]);
            send_word(op, pick_element(), pick_operand_b(op), 1'b0, none);
            sent++;
         end
      end
      start <= 1'b0;

      waited = 0;
      while (owed_outcomes.size() != 0 && waited < 100) begin
         @(posedge clock);
         waited++;
      end
      if (owed_outcomes.size() != 0) begin
         $error("%0d results never arrived", owed_outcomes.size());
         drain_timeout = 1'b1;
      end
      repeat (8) @(posedge clock);

      $display("%0d words driven: add %0d, mul %0d, div %0d, pow %0d, first one during the sweep",
               words_per_op[gfau_pkg::OP_ADD] + words_per_op[gfau_pkg::OP_MUL] +
               words_per_op[gfau_pkg::OP_DIV] + words_per_op[gfau_pkg::OP_POW],
               words_per_op[gfau_pkg::OP_ADD], words_per_op[gfau_pkg::OP_MUL],
               words_per_op[gfau_pkg::OP_DIV], words_per_op[gfau_pkg::OP_POW]);
      $display("%0d results checked, %0d of them with a zero divisor",
               results_checked, zero_divisors_seen);
      if (mismatches == 0 && !drain_timeout) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (owed_outcomes.size() == 0) begin
            $error("result 0x%02h with no word outstanding", rsp_field_result);
            mismatches++;
         end else begin
            oldest_outcome = owed_outcomes.pop_front();
            if (rsp_field_result !== oldest_outcome.elem) begin
               $error("field_result: expected 0x%02h, got 0x%02h",
                      oldest_outcome.elem, rsp_field_result);
               mismatches++;
            end
            if (rsp_divide_by_zero !== oldest_outcome.dz) begin
               $error("divide_by_zero: expected %0b, got %0b",
                      oldest_outcome.dz, rsp_divide_by_zero);
               mismatches++;
            end
            if (oldest_outcome.dz) zero_divisors_seen++;
            results_checked++;
         end
      end
   end

   initial begin
      #200us;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/gfau_pkg.sv
hw/rtl/gfau_ram.sv
hw/rtl/gfau_fill.sv
hw/rtl/gf256_arithmetic_unit.sv
tb/tb_gf256_arithmetic_unit.sv
